### rtl/flash_active_block_page_allocator_assert.svh
// ----------------------------------------------------------------------------
// flash active block page allocator assertion macros
// concurrent checks shared by the allocator modules
// ----------------------------------------------------------------------------
`ifndef FLASH_ACTIVE_BLOCK_PAGE_ALLOCATOR_ASSERT_SVH
`define FLASH_ACTIVE_BLOCK_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FABP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fabp implication check failed");

// next-cycle implication
`define FABP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fabp next-cycle check failed");

`endif

### rtl/fabp_pkg.sv
// ----------------------------------------------------------------------------
// fabp_pkg
// shared sizes, codes, types and helpers of the active block page allocator
// ----------------------------------------------------------------------------
package fabp_pkg;

  localparam int PLANES  = 8;
  localparam int BLOCKS  = 1024;
  localparam int PAGES   = 256;

  localparam int PLANE_W = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam int PTR_W   = 10;
  localparam int CNT_W   = 11;
  localparam int PG_W    = 9;
  localparam int PAGE_W  = 8;
  localparam int DEPTH   = PLANES * BLOCKS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int MODB_W  = $clog2(CNT_W);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES_PER_BLOCK = 1'b1;

  localparam logic [CNT_W-1:0] BC_RESET  = CNT_W'(1024);
  localparam logic [PG_W-1:0]  PPB_RESET = PG_W'(256);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_LOAD  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_PAGE_END = 2'd2
  } status_t;

  typedef struct packed {
    req_kind_t           kind;
    logic                load_ok;
    logic [PLANE_W-1:0]  plane;
    logic [PTR_W-1:0]    block;
    logic [PG_W-1:0]     free_pages;
    logic [PG_W-1:0]     next_page;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] block_count;
    logic [PG_W-1:0]  pages_per_block;
  } cfg_t;

  typedef struct packed {
    logic [PG_W-1:0] free_count;
    logic [PG_W-1:0] next_page;
  } store_t;

  function automatic logic [PLANE_W-1:0] plane_wrap(input logic [2:0] v);
    int r;
    r = int'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= PLANES) r = r - PLANES;
    end
    return PLANE_W'(r);
  endfunction

  function automatic logic [CNT_W-1:0] eff_blocks(input logic [CNT_W-1:0] bc);
    logic [CNT_W-1:0] n;
    n = bc;
    if (bc == '0) n = CNT_W'(1);
    else if (bc > CNT_W'(BLOCKS)) n = CNT_W'(BLOCKS);
    return n;
  endfunction

  function automatic logic [PG_W-1:0] eff_pages(input logic [PG_W-1:0] ppb);
    logic [PG_W-1:0] n;
    n = ppb;
    if (ppb > PG_W'(PAGES)) n = PG_W'(PAGES);
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [PLANE_W-1:0] plane,
                                                   input logic [PTR_W-1:0] blk);
    return ADDR_W'(plane) * ADDR_W'(BLOCKS) + ADDR_W'(blk);
  endfunction

endpackage

### rtl/fabp_if.sv
// ----------------------------------------------------------------------------
// fabp channel interfaces
// request, result and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fabp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [2:0] plane_index;
  logic [9:0] block_index;
  logic [8:0] free_pages;
  logic [8:0] next_page;

  modport source (output valid, req_type, plane_index, block_index, free_pages, next_page,
                  input ready);
  modport sink (input valid, req_type, plane_index, block_index, free_pages, next_page,
                output ready);
endinterface

interface fabp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] alloc_block;
  logic [7:0] alloc_page;
  logic [9:0] spare_block;

  modport source (output valid, status, alloc_block, alloc_page, spare_block,
                  input ready);
  modport sink (input valid, status, alloc_block, alloc_page, spare_block,
                output ready);
endinterface

interface fabp_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fabp_pkg::CFG_IDX_W-1:0]      index;
  logic [fabp_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/fabp_ram.sv
// ----------------------------------------------------------------------------
// fabp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fabp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/fabp_front.sv
// ----------------------------------------------------------------------------
// fabp_front
// accepts requests, decodes plane and load range, queues them for the back end
// ----------------------------------------------------------------------------
`include "flash_active_block_page_allocator_assert.svh"

module fabp_front (
  input  logic                clk,
  input  logic                rst_n,
  fabp_in_if.sink             in_ch,
  output fabp_pkg::q_head_t   head,
  input  fabp_pkg::back_ctl_t ctl
);

  fabp_pkg::q_item_t                q_r [fabp_pkg::QDEPTH];
  logic [fabp_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [fabp_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [fabp_pkg::QCNT_W-1:0]      count_r;
  fabp_pkg::q_item_t                dec;
  logic                             push;

  // classify the incoming request
  always_comb begin
    dec.kind       = in_ch.req_type ? fabp_pkg::REQ_LOAD : fabp_pkg::REQ_ALLOC;
    dec.load_ok    = {1'b0, in_ch.block_index} < fabp_pkg::CNT_W'(fabp_pkg::BLOCKS);
    dec.plane      = fabp_pkg::plane_wrap(in_ch.plane_index);
    dec.block      = in_ch.block_index;
    dec.free_pages = in_ch.free_pages;
    dec.next_page  = in_ch.next_page;
  end

  assign in_ch.ready = (count_r != fabp_pkg::QCNT_W'(fabp_pkg::QDEPTH)) && !ctl.clearing;
  assign push        = in_ch.valid && in_ch.ready;

  assign head.valid = (count_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= dec;
        wr_ptr_r      <= wr_ptr_r + fabp_pkg::QPTR_W'(1);
      end
      if (ctl.pop) begin
        rd_ptr_r <= rd_ptr_r + fabp_pkg::QPTR_W'(1);
      end
      case ({push, ctl.pop})
        2'b10:   count_r <= count_r + fabp_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - fabp_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  `FABP_ASSERT_IMP(a_pop_nonempty, clk, rst_n, ctl.pop, count_r != '0)
  `FABP_ASSERT_IMP(a_no_take_clear, clk, rst_n, ctl.clearing, !in_ch.ready)

endmodule

### rtl/fabp_back.sv
// ----------------------------------------------------------------------------
// fabp_back
// clears the block stores, writes loaded entries, runs the two pointer walks and the page allocation
// ----------------------------------------------------------------------------
`include "flash_active_block_page_allocator_assert.svh"

module fabp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fabp_pkg::q_head_t   head,
  output fabp_pkg::back_ctl_t ctl,
  input  fabp_pkg::cfg_t      cfg,
  fabp_out_if.source          out_ch
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_MOD,
    S_WB,
    S_FIN,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [fabp_pkg::ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  fabp_pkg::q_item_t               item_r, item_nxt;
  logic [fabp_pkg::PTR_W-1:0]      act_r, act_nxt;
  logic [fabp_pkg::PTR_W-1:0]      spr_r, spr_nxt;
  logic                            phase_r, phase_nxt;
  logic                            fail_r, fail_nxt;
  logic [fabp_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [fabp_pkg::CNT_W-1:0]      nb_r, nb_nxt;
  logic [fabp_pkg::CNT_W-1:0]      mod_rem_r, mod_rem_nxt;
  logic [fabp_pkg::CNT_W-1:0]      mod_div_r, mod_div_nxt;
  logic [fabp_pkg::MODB_W-1:0]     mod_bit_r, mod_bit_nxt;
  fabp_pkg::status_t               res_status_r, res_status_nxt;
  logic [fabp_pkg::PAGE_W-1:0]     res_page_r, res_page_nxt;
  logic [fabp_pkg::PTR_W-1:0]      active_ptr_r [fabp_pkg::PLANES];
  logic [fabp_pkg::PTR_W-1:0]      active_ptr_nxt [fabp_pkg::PLANES];
  logic [fabp_pkg::PTR_W-1:0]      spare_ptr_r [fabp_pkg::PLANES];
  logic [fabp_pkg::PTR_W-1:0]      spare_ptr_nxt [fabp_pkg::PLANES];
  logic                            out_valid_r, out_valid_nxt;
  fabp_pkg::status_t               out_status_r, out_status_nxt;
  logic [fabp_pkg::PTR_W-1:0]      out_block_r, out_block_nxt;
  logic [fabp_pkg::PAGE_W-1:0]     out_page_r, out_page_nxt;
  logic [fabp_pkg::PTR_W-1:0]      out_spare_r, out_spare_nxt;

  logic                            ram_we;
  logic [fabp_pkg::ADDR_W-1:0]     ram_waddr;
  fabp_pkg::store_t                ram_wdata;
  logic [fabp_pkg::ADDR_W-1:0]     ram_raddr;
  fabp_pkg::store_t                ram_rdata;
  fabp_pkg::store_t                rd;
  fabp_pkg::store_t                wr;

  logic                            out_free;
  logic [fabp_pkg::PTR_W-1:0]      cur;
  logic [fabp_pkg::PTR_W-1:0]      other;
  logic [fabp_pkg::CNT_W-1:0]      step_nx;
  logic [fabp_pkg::CNT_W:0]        mod_sh;
  logic [fabp_pkg::CNT_W:0]        mod_sub;
  logic [fabp_pkg::CNT_W-1:0]      mod_res;
  logic [fabp_pkg::PTR_W-1:0]      new_ptr;
  logic                            new_ptr_ok;
  logic                            pop;

  fabp_ram #(
    .WIDTH ($bits(fabp_pkg::store_t)),
    .DEPTH (fabp_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = ram_rdata;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cur      = phase_r ? spr_r : act_r;
  assign other    = phase_r ? act_r : spr_r;
  assign step_nx  = fabp_pkg::CNT_W'(cur) + fabp_pkg::CNT_W'(1);

  // one bit of the restoring remainder per cycle
  assign mod_sh  = {mod_rem_r, mod_div_r[mod_bit_r]};
  assign mod_sub = mod_sh - {1'b0, nb_r};
  assign mod_res = (mod_sh >= {1'b0, nb_r}) ? mod_sub[fabp_pkg::CNT_W-1:0]
                                            : mod_sh[fabp_pkg::CNT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    item_nxt       = item_r;
    act_nxt        = act_r;
    spr_nxt        = spr_r;
    phase_nxt      = phase_r;
    fail_nxt       = fail_r;
    cnt_nxt        = cnt_r;
    nb_nxt         = nb_r;
    mod_rem_nxt    = mod_rem_r;
    mod_div_nxt    = mod_div_r;
    mod_bit_nxt    = mod_bit_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    active_ptr_nxt = active_ptr_r;
    spare_ptr_nxt  = spare_ptr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_page_nxt   = out_page_r;
    out_spare_nxt  = out_spare_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_addr_r;
    wr             = '0;
    ram_raddr      = fabp_pkg::store_addr(item_r.plane, cur);
    new_ptr        = '0;
    new_ptr_ok     = 1'b0;
    pop            = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_r == fabp_pkg::ADDR_W'(fabp_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + fabp_pkg::ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          item_nxt = head.item;
          if (head.item.kind == fabp_pkg::REQ_LOAD) begin
            ram_we         = head.item.load_ok;
            ram_waddr      = fabp_pkg::store_addr(head.item.plane, head.item.block);
            wr.free_count  = head.item.free_pages;
            wr.next_page   = head.item.next_page;
            res_status_nxt = fabp_pkg::ST_OK;
            res_page_nxt   = '0;
            state_nxt      = S_DONE;
          end else begin
            act_nxt   = active_ptr_r[head.item.plane];
            spr_nxt   = spare_ptr_r[head.item.plane];
            phase_nxt = 1'b0;
            fail_nxt  = 1'b0;
            cnt_nxt   = '0;
            nb_nxt    = fabp_pkg::eff_blocks(cfg.block_count);
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        if (cnt_r >= nb_r) begin
          // step budget used up
          fail_nxt = 1'b1;
          if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            state_nxt = S_WB;
          end
        end else begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (rd.free_count == '0 || cur == other) begin
          cnt_nxt = cnt_r + fabp_pkg::CNT_W'(1);
          if (step_nx < nb_r) begin
            new_ptr    = step_nx[fabp_pkg::PTR_W-1:0];
            new_ptr_ok = 1'b1;
            state_nxt  = S_READ;
          end else if (step_nx == nb_r) begin
            new_ptr    = '0;
            new_ptr_ok = 1'b1;
            state_nxt  = S_READ;
          end else begin
            // pointer left beyond a lowered block count
            mod_rem_nxt = '0;
            mod_div_nxt = step_nx;
            mod_bit_nxt = fabp_pkg::MODB_W'(fabp_pkg::CNT_W - 1);
            state_nxt   = S_MOD;
          end
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_WB;
        end
      end

      S_MOD: begin
        mod_rem_nxt = mod_res;
        if (mod_bit_r == '0) begin
          new_ptr    = mod_res[fabp_pkg::PTR_W-1:0];
          new_ptr_ok = 1'b1;
          state_nxt  = S_READ;
        end else begin
          mod_bit_nxt = mod_bit_r - fabp_pkg::MODB_W'(1);
        end
      end

      S_WB: begin
        active_ptr_nxt[item_r.plane] = act_r;
        spare_ptr_nxt[item_r.plane]  = spr_r;
        ram_raddr = fabp_pkg::store_addr(item_r.plane, act_r);
        if (fail_r) begin
          res_status_nxt = fabp_pkg::ST_NO_FREE;
          res_page_nxt   = '0;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (rd.next_page >= fabp_pkg::eff_pages(cfg.pages_per_block)) begin
          res_status_nxt = fabp_pkg::ST_PAGE_END;
          res_page_nxt   = '0;
        end else begin
          res_status_nxt = fabp_pkg::ST_OK;
          res_page_nxt   = rd.next_page[fabp_pkg::PAGE_W-1:0];
          ram_we         = 1'b1;
          ram_waddr      = fabp_pkg::store_addr(item_r.plane, act_r);
          wr.next_page   = rd.next_page + fabp_pkg::PG_W'(1);
          wr.free_count  = (rd.free_count != '0) ? rd.free_count - fabp_pkg::PG_W'(1)
                                                 : rd.free_count;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
          if (item_r.kind == fabp_pkg::REQ_LOAD) begin
            out_block_nxt = '0;
            out_spare_nxt = '0;
          end else begin
            out_block_nxt = act_r;
            out_spare_nxt = spr_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (new_ptr_ok) begin
      if (phase_r) spr_nxt = new_ptr;
      else act_nxt = new_ptr;
    end
  end

  assign ram_wdata    = wr;
  assign ctl.pop      = pop;
  assign ctl.clearing = (state_r == S_CLEAR);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.alloc_block = out_block_r;
  assign out_ch.alloc_page  = out_page_r;
  assign out_ch.spare_block = out_spare_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      nb_r        <= fabp_pkg::CNT_W'(1);
      for (int p = 0; p < fabp_pkg::PLANES; p++) begin
        active_ptr_r[p] <= '0;
        spare_ptr_r[p]  <= fabp_pkg::PTR_W'(1);
      end
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      nb_r         <= nb_nxt;
      active_ptr_r <= active_ptr_nxt;
      spare_ptr_r  <= spare_ptr_nxt;
    end
    item_r       <= item_nxt;
    act_r        <= act_nxt;
    spr_r        <= spr_nxt;
    phase_r      <= phase_nxt;
    fail_r       <= fail_nxt;
    mod_rem_r    <= mod_rem_nxt;
    mod_div_r    <= mod_div_nxt;
    mod_bit_r    <= mod_bit_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_page_r   <= out_page_nxt;
    out_spare_r  <= out_spare_nxt;
  end

  `FABP_ASSERT_IMP(a_walk_no_write, clk, rst_n,
    (state_r == S_READ || state_r == S_CHECK || state_r == S_MOD), !ram_we)
  `FABP_ASSERT_IMP(a_budget_bound, clk, rst_n,
    (state_r == S_READ || state_r == S_CHECK || state_r == S_MOD), cnt_r <= nb_r)
  `FABP_ASSERT_NXT(a_result_posted, clk, rst_n, (state_r == S_DONE && out_free), out_valid_r)

endmodule

### rtl/flash_active_block_page_allocator.sv
// after reset the block stores are cleared, one entry per cycle, all PLANES*BLOCKS (8192) entries,
// while no request is taken; register writes are taken at all times
// load: S_IDLE writes the store entry, S_DONE posts the result; allocate: S_READ, S_CHECK per block,
// S_MOD to wrap a pointer at or above a lowered block count, then S_WB, S_FIN (if found), S_DONE
// throughput: one request at a time through the walk sequencer and its single store read port
// reset: synchronous active-low rst_n clears control state and loads register defaults
// ----------------------------------------------------------------------------
// flash_active_block_page_allocator
// per-plane active/spare block pointers with page allocation from block counters
// ----------------------------------------------------------------------------
module flash_active_block_page_allocator (
  input  logic      clk,
  input  logic      rst_n,
  fabp_in_if.sink   in_ch,
  fabp_out_if.source out_ch,
  fabp_cfg_if.sink  cfg_ch
);

  fabp_pkg::q_head_t   head;
  fabp_pkg::back_ctl_t ctl;
  fabp_pkg::cfg_t      cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_count     <= fabp_pkg::BC_RESET;
      cfg_r.pages_per_block <= fabp_pkg::PPB_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        fabp_pkg::REG_BLOCK_COUNT:     cfg_r.block_count <= cfg_ch.data[fabp_pkg::CNT_W-1:0];
        fabp_pkg::REG_PAGES_PER_BLOCK: cfg_r.pages_per_block <= cfg_ch.data[fabp_pkg::PG_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  fabp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .ctl   (ctl)
  );

  fabp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .ctl    (ctl),
    .cfg    (cfg_r),
    .out_ch (out_ch)
  );

endmodule
